>>> hdl/umtc_pkg.sv
// Shared types, constants and the soft-threshold weight curve for the
// unsharp-mask combine block. No dependencies.
`default_nettype none

package umtc_pkg;

    localparam int unsigned NUM_STAGES = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_AMOUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [14:0] WEIGHT_DIVISOR = 15'd25500;
    // floor(2^40 / 25500); the quotient is at most one short after the shift.
    localparam logic [25:0] RECIP_MULT  = 26'd43118103;
    localparam int unsigned RECIP_SHIFT = 40;

    localparam int unsigned WEIGHT_HALF_LEN = 54;
    localparam logic [7:0] WEIGHT_HALF [0:WEIGHT_HALF_LEN-1] = '{
        8'd128, 8'd135, 8'd142, 8'd150, 8'd157, 8'd164, 8'd171, 8'd177, 8'd183, 8'd189,
        8'd195, 8'd200, 8'd205, 8'd209, 8'd214, 8'd217, 8'd221, 8'd224, 8'd227, 8'd230,
        8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd242, 8'd243, 8'd245, 8'd246, 8'd247,
        8'd248, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252, 8'd252, 8'd252,
        8'd253, 8'd253, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd254, 8'd254, 8'd254, 8'd254
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } umtc_ctrl_t;

    // Sigmoid weight of k = |diff| - threshold, using point symmetry about 127.5.
    function automatic logic [7:0] weight_of(input logic signed [8:0] k);
        logic [8:0] kabs;
        logic [7:0] mag;
        logic [7:0] w;
        kabs = k[8] ? 9'(-k) : 9'(k);
        mag  = kabs[7:0];
        if (mag < 8'(WEIGHT_HALF_LEN)) begin
            w = WEIGHT_HALF[mag[5:0]];
        end else begin
            w = 8'd255;
        end
        if (k[8]) begin
            w = 8'd255 - w;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/unsharp_mask_threshold_combine.sv
// Top level of the unsharp-mask combine block: stream ports, configuration
// registers, pipeline control and three umtc_lane instances. Uses umtc_pkg.
`default_nettype none

// Each word on the slave side is one RGBA pixel with its blurred RGB values; the
// master side returns the sharpened RGBA pixel at the end of the pipeline. The block takes
// one word per clock and sustains that rate as long as m_tready stays high; the
// six register stages (difference, weight lookup and first multiply, second
// multiply, reciprocal multiply, quotient correction, clamp) set the latency.
// When the output stalls, empty stages still fill, so s_tready falls only once
// every stage holds a word. Write amount and threshold only while no pixels are
// in flight; the configuration port is always ready.
module unsharp_mask_threshold_combine (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // orig_red, orig_green, orig_blue, orig_alpha, blur_red, blur_green, blur_blue
    input  wire logic [55:0]                          s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // sharp_red, sharp_green, sharp_blue, sharp_alpha
    output logic [31:0]                               m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [umtc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [umtc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import umtc_pkg::*;

    logic [8:0]            amount_reg;
    logic [7:0]            threshold_reg;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] ready;
    logic [7:0]            alpha_reg [0:NUM_STAGES-1];
    umtc_ctrl_t            ctrl;
    logic [7:0]            sharp_red, sharp_green, sharp_blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amount_reg    <= '0;
            threshold_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_AMOUNT:    amount_reg    <= cfg_data[8:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
        ctrl.load = ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            alpha_reg[0] <= s_tdata[31:24];
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    umtc_lane u_lane_red (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .amount    (amount_reg),
        .threshold (threshold_reg),
        .orig      (s_tdata[7:0]),
        .blur      (s_tdata[39:32]),
        .sharp     (sharp_red)
    );

    umtc_lane u_lane_green (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .amount    (amount_reg),
        .threshold (threshold_reg),
        .orig      (s_tdata[15:8]),
        .blur      (s_tdata[47:40]),
        .sharp     (sharp_green)
    );

    umtc_lane u_lane_blue (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .amount    (amount_reg),
        .threshold (threshold_reg),
        .orig      (s_tdata[23:16]),
        .blur      (s_tdata[55:48]),
        .sharp     (sharp_blue)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {alpha_reg[NUM_STAGES-1], sharp_blue, sharp_green, sharp_red};

endmodule

`default_nettype wire

>>> hdl/umtc_lane.sv
// Six-stage datapath for one color channel: difference, weight lookup,
// two multiplies, reciprocal division by 25500 and clamp. Uses umtc_pkg.
`default_nettype none

module umtc_lane (
    input  wire logic                 aclk,
    input  wire umtc_pkg::umtc_ctrl_t ctrl,
    input  wire logic [8:0]           amount,
    input  wire logic [7:0]           threshold,
    input  wire logic [7:0]           orig,
    input  wire logic [7:0]           blur,
    output logic [7:0]                sharp
);
    import umtc_pkg::*;

    logic [7:0]        o1_reg, o2_reg, o3_reg, o4_reg, o5_reg;
    logic              neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [7:0]        mag1_reg;
    logic signed [8:0] k1_reg;
    logic [7:0]        w2_reg;
    logic [16:0]       ma2_reg;
    logic [24:0]       x3_reg, x4_reg;
    logic [10:0]       q4_reg, q5_reg;
    logic [7:0]        sharp_reg;

    logic signed [8:0] diff;
    logic [7:0]        mag;
    logic [50:0]       recip_prod;
    logic [25:0]       back_prod;
    logic [24:0]       remainder;
    logic signed [12:0] sum;
    logic [7:0]        sharp_next;

    always_comb begin
        diff = $signed({1'b0, orig}) - $signed({1'b0, blur});
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
        recip_prod = 51'(x3_reg) * 51'(RECIP_MULT);
        back_prod  = 26'(q4_reg) * 26'(WEIGHT_DIVISOR);
        remainder  = x4_reg - back_prod[24:0];
        if (neg5_reg) begin
            sum = $signed({5'd0, o5_reg}) - $signed({2'd0, q5_reg});
        end else begin
            sum = $signed({5'd0, o5_reg}) + $signed({2'd0, q5_reg});
        end
        if (sum < 0) begin
            sharp_next = 8'd0;
        end else if (sum > 13'sd255) begin
            sharp_next = 8'd255;
        end else begin
            sharp_next = sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            o1_reg   <= orig;
            neg1_reg <= diff[8];
            mag1_reg <= mag;
            k1_reg   <= $signed({1'b0, mag}) - $signed({1'b0, threshold});
        end
        if (ctrl.load[1]) begin
            o2_reg   <= o1_reg;
            neg2_reg <= neg1_reg;
            w2_reg   <= weight_of(k1_reg);
            ma2_reg  <= 17'(mag1_reg) * 17'(amount);
        end
        if (ctrl.load[2]) begin
            o3_reg   <= o2_reg;
            neg3_reg <= neg2_reg;
            x3_reg   <= 25'(ma2_reg) * 25'(w2_reg);
        end
        if (ctrl.load[3]) begin
            o4_reg   <= o3_reg;
            neg4_reg <= neg3_reg;
            x4_reg   <= x3_reg;
            q4_reg   <= recip_prod[RECIP_SHIFT +: 11];
        end
        if (ctrl.load[4]) begin
            o5_reg   <= o4_reg;
            neg5_reg <= neg4_reg;
            q5_reg   <= q4_reg + 11'(remainder >= 25'(WEIGHT_DIVISOR));
        end
        if (ctrl.load[5]) begin
            sharp_reg <= sharp_next;
        end
    end

    assign sharp = sharp_reg;

endmodule

`default_nettype wire

>>> hdl/umtc_checker.sv
// Port-level checks for unsharp_mask_threshold_combine, attached by the bind
// statement at the end of this file. No package dependencies.
`default_nettype none

module umtc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready
);

    // A stalled output word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Input backpressure only comes from a stalled full output.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the output is free");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind unsharp_mask_threshold_combine umtc_checker u_umtc_checker (.*);

`default_nettype wire

>>> verif/tb_unsharp_mask_threshold_combine.sv
// Self-checking testbench for unsharp_mask_threshold_combine: drives pixel words
// with random gaps and stalls, predicts each sharpened pixel and compares it.
// Depends on umtc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_unsharp_mask_threshold_combine;

    import umtc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS = 240;
    localparam int SIGMOID_LEN = 54;
    localparam int SIGMOID [0:SIGMOID_LEN-1] = '{
        128, 135, 142, 150, 157, 164, 171, 177, 183, 189,
        195, 200, 205, 209, 214, 217, 221, 224, 227, 230,
        233, 235, 237, 239, 241, 242, 243, 245, 246, 247,
        248, 248, 249, 250, 250, 251, 251, 252, 252, 252,
        253, 253, 253, 253, 254, 254, 254, 254, 254, 254,
        254, 254, 254, 254
    };

    // Fields are listed from the highest bit down, so the struct packs like tdata.
    typedef struct packed {
        logic [7:0] blur_blue;
        logic [7:0] blur_green;
        logic [7:0] blur_red;
        logic [7:0] orig_alpha;
        logic [7:0] orig_blue;
        logic [7:0] orig_green;
        logic [7:0] orig_red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] sharp_alpha;
        logic [7:0] sharp_blue;
        logic [7:0] sharp_green;
        logic [7:0] sharp_red;
    } sharp_t;

    class umtc_scoreboard;
        int amount;
        int thresh;
        int errors;
        int seen;
        sharp_t sharp_queue[$];

        function new();
            amount = 0;
            thresh = 0;
            errors = 0;
            seen = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_AMOUNT: begin
                    amount = int'(val);
                end
                CFG_THRESHOLD: begin
                    thresh = int'(val[7:0]);
                end
                default: begin
                end
            endcase
        endfunction

        function logic [7:0] sharpen(logic [7:0] o, logic [7:0] b);
            int diff;
            int mag;
            int k;
            int w;
            int v;
            diff = int'(o) - int'(b);
            mag = (diff < 0) ? -diff : diff;
            k = mag - thresh;
            w = (k < 0) ? -k : k;
            w = (w < SIGMOID_LEN) ? SIGMOID[w] : 255;
            if (k < 0) begin
                w = 255 - w;
            end
            v = int'(o) + (diff * amount * w) / 25500;
            if (v < 0) begin
                v = 0;
            end
            if (v > 255) begin
                v = 255;
            end
            return v[7:0];
        endfunction

        function void note_pixel(pixel_t px);
            sharp_t s;
            s.sharp_red = sharpen(px.orig_red, px.blur_red);
            s.sharp_green = sharpen(px.orig_green, px.blur_green);
            s.sharp_blue = sharpen(px.orig_blue, px.blur_blue);
            s.sharp_alpha = px.orig_alpha;
            sharp_queue.push_back(s);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_word(sharp_t got);
            sharp_t want;
            seen++;
            if (sharp_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                return;
            end
            want = sharp_queue.pop_front();
            compare("sharp_red", want.sharp_red, got.sharp_red);
            compare("sharp_green", want.sharp_green, got.sharp_green);
            compare("sharp_blue", want.sharp_blue, got.sharp_blue);
            compare("sharp_alpha", want.sharp_alpha, got.sharp_alpha);
        endfunction

        function int pending();
            return sharp_queue.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [55:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [31:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    umtc_scoreboard board = new();
    bit steady = 1'b0;
    int cycles = 0;

    unsharp_mask_threshold_combine dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_word(m_tdata);
        end
    end

    // The receiver holds off once for a long stretch while pixels keep coming.
    initial begin : receiver
        int hold;
        bit squeezed;
        hold = 0;
        squeezed = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!squeezed && board.seen >= 400 && s_tvalid) begin
                squeezed = 1'b1;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    function automatic pixel_t make_pixel(int or_, int og, int ob, int oa,
                                          int br, int bg, int bb);
        pixel_t px;
        px.orig_red = or_[7:0];
        px.orig_green = og[7:0];
        px.orig_blue = ob[7:0];
        px.orig_alpha = oa[7:0];
        px.blur_red = br[7:0];
        px.blur_green = bg[7:0];
        px.blur_blue = bb[7:0];
        return px;
    endfunction

    // Many channels get a difference near the threshold to exercise the curve.
    function automatic pixel_t random_pixel(int thr);
        int o [3];
        int b [3];
        int mag;
        for (int c = 0; c < 3; c++) begin
            o[c] = $urandom_range(255);
            b[c] = $urandom_range(255);
            if ($urandom_range(99) < 45) begin
                mag = thr + $urandom_range(120) - 60;
                if (mag < 0) begin
                    mag = 0;
                end
                if (mag > 255) begin
                    mag = 255;
                end
                if (o[c] >= mag && ($urandom_range(1) == 1 || o[c] + mag > 255)) begin
                    b[c] = o[c] - mag;
                end else if (o[c] + mag <= 255) begin
                    b[c] = o[c] + mag;
                end
            end
        end
        return make_pixel(o[0], o[1], o[2], $urandom_range(255), b[0], b[1], b[2]);
    endfunction

    task automatic send_pixel(input pixel_t px);
        while (!steady && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        board.note_pixel(px);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic configure(input int amt, input int thr);
        logic [CFG_INDEX_W-1:0] regs [2];
        logic [CFG_DATA_W-1:0] vals [2];
        regs[0] = CFG_AMOUNT;
        regs[1] = CFG_THRESHOLD;
        vals[0] = amt[CFG_DATA_W-1:0];
        vals[1] = thr[CFG_DATA_W-1:0];
        drain();
        for (int i = 0; i < 2; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) begin
                @(posedge aclk);
            end
            board.set_register(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_amount [RANDOM_PHASES];
        int phase_thresh [RANDOM_PHASES];
        int amt;
        int thr;
        phase_amount = '{100, 511, 0, 500, -1, -1, -1, -1};
        phase_thresh = '{0, 255, 17, 128, -1, -1, 0, 255};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_AMOUNT;
        cfg_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero amount leaves every color channel as it was.
        configure(0, 0);
        send_pixel(make_pixel(255, 0, 128, 0, 0, 255, 128));
        send_pixel(make_pixel(17, 200, 90, 255, 240, 3, 91));

        // Amount above its range, threshold zero: clamping at both ends and the curve edge.
        configure(511, 0);
        send_pixel(make_pixel(255, 0, 128, 255, 0, 255, 128));
        send_pixel(make_pixel(0, 255, 1, 170, 0, 255, 0));
        send_pixel(make_pixel(100, 100, 100, 85, 99, 101, 154));
        send_pixel(make_pixel(200, 50, 128, 1, 146, 104, 74));
        send_pixel(make_pixel(200, 50, 128, 254, 147, 103, 75));

        // Highest amount in range with the highest threshold.
        configure(500, 255);
        send_pixel(make_pixel(255, 0, 200, 0, 0, 255, 10));
        send_pixel(make_pixel(255, 0, 60, 255, 1, 254, 0));
        send_pixel(make_pixel(128, 128, 128, 128, 128, 128, 128));

        // Differences around a middle threshold, on both sides of the curve center.
        configure(137, 40);
        send_pixel(make_pixel(100, 100, 100, 0, 60, 140, 100));
        send_pixel(make_pixel(100, 100, 100, 0, 59, 141, 70));
        send_pixel(make_pixel(100, 100, 100, 0, 6, 194, 160));
        send_pixel(make_pixel(100, 100, 100, 0, 7, 193, 200));
        send_pixel(make_pixel(0, 255, 255, 0, 255, 0, 0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            amt = (phase_amount[p] < 0) ? $urandom_range(511) : phase_amount[p];
            thr = (phase_thresh[p] < 0) ? $urandom_range(255) : phase_thresh[p];
            configure(amt, thr);
            steady = (p == 3);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                send_pixel(random_pixel(thr));
            end
            steady = 1'b0;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/umtc_pkg.sv
hdl/umtc_lane.sv
hdl/unsharp_mask_threshold_combine.sv
hdl/umtc_checker.sv
verif/tb_unsharp_mask_threshold_combine.sv
